// ----- sv/fnvch_pkg.sv -----
// Shared types, constants and hash functions for the chained snapshot hasher.
package fnvch_pkg;

   localparam logic [63:0] HASH_SEED  = 64'd1469598103934665603;
   localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;

   localparam logic [2:0] MODE_BYTE        = 3'd0;
   localparam logic [2:0] MODE_CLOSE_PATH  = 3'd1;
   localparam logic [2:0] MODE_CLOSE_SFX   = 3'd2;
   localparam logic [2:0] MODE_EMIT_SET    = 3'd3;
   localparam logic [2:0] MODE_EMIT_STRING = 3'd4;

   localparam logic KIND_STRING = 1'b0;
   localparam logic KIND_SET    = 1'b1;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [63:0] hash_value;
      logic        hash_kind;
   } rsp_type;

   // One transaction handed from the input stage to the accumulators.
   typedef struct packed {
      logic    valid;
      req_type item;
   } step_type;

   // The FNV prime is 2^40 + 2^8 + 0xb3, so the multiply is a short shift-add.
   function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

   function automatic logic [63:0] mix_in(input logic [63:0] h, input logic [63:0] v);
      return h ^ (v + MIX_GOLDEN + (h << 6) + (h >> 2));
   endfunction

endpackage

// ----- sv/fnv_chained_snapshot_hash.sv -----
// Top level of the chained snapshot hasher: input stage, accumulators and result register.
// The block takes one transaction per cycle. Each accepted transaction sits in an input
// register, where its byte fold or string close updates the accumulators, and an emit
// transaction then moves on into the result register, which drives rsp_. The only stall
// on req_ comes from an emit that finds the result register still full and stalled;
// byte and close transactions never wait.
module fnv_chained_snapshot_hash
   import fnvch_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     stage_valid_ff, stage_valid_in;
   req_type  stage_item_ff;
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_data_ff;
   logic     stage_emit;
   logic     advance;
   step_type step;
   rsp_type  result;

   assign stage_emit = (stage_item_ff.mode == MODE_EMIT_SET) ||
                       (stage_item_ff.mode == MODE_EMIT_STRING);
   assign advance    = stage_valid_ff && (!stage_emit || !out_valid_ff || !rsp_stall);
   assign req_stall  = stage_valid_ff && !advance;

   assign step.valid = advance;
   assign step.item  = stage_item_ff;

   fnvch_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .result (result)
   );

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (!req_stall) begin
         stage_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      if (advance && stage_emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         stage_item_ff <= req_data;
      end
      if (advance && stage_emit) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A new result only ever comes from an emit transaction leaving the input stage.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(advance && stage_emit))
      else $error("result appeared without an emit transaction");

   // Only a blocked emit may hold up the request side.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (stage_emit && rsp_valid && rsp_stall))
      else $error("request stalled without a blocked result");

   // A result taken while an emit advances is replaced, never dropped.
   a_refill: assert property (@(posedge clock) disable iff (reset)
      (advance && stage_emit) |=> rsp_valid)
      else $error("emit advanced but no result was held");

endmodule

// ----- sv/fnvch_accum.sv -----
// String, entry and set hash accumulators with their per-mode update logic.
module fnvch_accum
   import fnvch_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  step_type step,
   output rsp_type  result
);

   logic [63:0] string_ff, string_in;
   logic [63:0] entry_ff, entry_in;
   logic [63:0] set_ff, set_in;
   logic [63:0] entry_mixed;

   always_comb begin
      string_in   = string_ff;
      entry_in    = entry_ff;
      set_in      = set_ff;
      entry_mixed = mix_in(entry_ff, string_ff);
      if (step.valid) begin
         unique case (step.item.mode)
            MODE_BYTE: begin
               string_in = fnv_fold(string_ff, step.item.data_byte);
            end
            MODE_CLOSE_PATH: begin
               entry_in  = string_ff;
               string_in = HASH_SEED;
            end
            MODE_CLOSE_SFX: begin
               // The set combine sees the entry after the suffix went into it.
               entry_in  = entry_mixed;
               set_in    = mix_in(set_ff, entry_mixed);
               string_in = HASH_SEED;
            end
            MODE_EMIT_SET: begin
               set_in = HASH_SEED;
            end
            MODE_EMIT_STRING: begin
               string_in = HASH_SEED;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (step.item.mode == MODE_EMIT_SET) begin
         result.hash_value = set_ff;
         result.hash_kind  = KIND_SET;
      end else begin
         result.hash_value = string_ff;
         result.hash_kind  = KIND_STRING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         string_ff <= HASH_SEED;
         entry_ff  <= 64'd0;
         set_ff    <= HASH_SEED;
      end else begin
         string_ff <= string_in;
         entry_ff  <= entry_in;
         set_ff    <= set_in;
      end
   end

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the chained snapshot hasher with random flow control on both ports.
module tb;
   import fnvch_pkg::*;

   localparam logic [63:0] FNV_PRIME        = 64'd1099511628211;
   localparam logic [2:0]  MODE_FIRST_SPARE = 3'd5;
   localparam logic [2:0]  MODE_LAST_SPARE  = 3'd7;
   localparam int          RANDOM_ITEMS     = 1550;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Mirror of the hasher state, advanced once per accepted request.
   logic [63:0] string_hash = HASH_SEED;
   logic [63:0] entry_hash  = 64'd0;
   logic [63:0] set_hash    = HASH_SEED;

   req_type pending_items[$];
   rsp_type expected_hashes[$];

   int queued_count     = 0;
   int snapshot_count   = 0;
   int accepted_count   = 0;
   int checked_count    = 0;
   int fail_count       = 0;
   int burst_left       = 1;
   int gap_left         = 0;
   int stall_left       = 0;
   stall_style_type stall_style = STALL_NONE;

   fnv_chained_snapshot_hash i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [63:0] fold_byte(input logic [63:0] h, input logic [7:0] b);
      return (h ^ {56'd0, b}) * FNV_PRIME;
   endfunction

   function automatic logic [63:0] combine(input logic [63:0] acc, input logic [63:0] v);
      return acc ^ (v + MIX_GOLDEN + (acc << 6) + (acc >> 2));
   endfunction

   function automatic void advance_hashes(input req_type r);
      case (r.mode)
         MODE_BYTE: begin
            string_hash = fold_byte(string_hash, r.data_byte);
         end
         MODE_CLOSE_PATH: begin
            entry_hash  = string_hash;
            string_hash = HASH_SEED;
         end
         MODE_CLOSE_SFX: begin
            entry_hash  = combine(entry_hash, string_hash);
            set_hash    = combine(set_hash, entry_hash);
            string_hash = HASH_SEED;
         end
         MODE_EMIT_SET: begin
            expected_hashes.insert(expected_hashes.size(),
                                   rsp_type'{hash_value: set_hash, hash_kind: KIND_SET});
            set_hash = HASH_SEED;
         end
         MODE_EMIT_STRING: begin
            expected_hashes.insert(expected_hashes.size(),
                                   rsp_type'{hash_value: string_hash,
                                             hash_kind: KIND_STRING});
            string_hash = HASH_SEED;
         end
         default: begin
         end
      endcase
   endfunction

   task automatic push_item(input logic [2:0] mode, input logic [7:0] b);
      pending_items.insert(pending_items.size(), req_type'{mode: mode, data_byte: b});
      if (mode < MODE_FIRST_SPARE) begin
         queued_count++;
      end
   endtask

   task automatic push_text(input string s);
      foreach (s[i]) begin
         push_item(MODE_BYTE, s[i]);
      end
   endtask

   task automatic push_random_bytes(input int max_len);
      int len;
      len = $urandom_range(0, max_len);
      repeat (len) begin
         push_item(MODE_BYTE, 8'($urandom_range(0, 255)));
      end
   endtask

   // Control item with a random, ignored byte so the data field also toggles on non-byte modes.
   task automatic push_control(input logic [2:0] mode);
      push_item(mode, 8'($urandom_range(0, 255)));
   endtask

   // One well-formed snapshot: path and suffix pairs folded into the set, then the set emitted.
   task automatic push_snapshot();
      int entries;
      entries = $urandom_range(0, 5);
      repeat (entries) begin
         push_random_bytes(10);
         push_control(MODE_CLOSE_PATH);
         case ($urandom_range(0, 3))
            0: push_text($sformatf("%0d", $urandom_range(1_000_000, 2_000_000_000)));
            1: push_text("MISSING");
            2: push_text("UNSTAMPED");
            default: begin
            end
         endcase
         push_control(MODE_CLOSE_SFX);
      end
      push_control(MODE_EMIT_SET);
      snapshot_count++;
   endtask

   // Sender: bursts of random length separated by random gaps; a stalled item is held.
   always @(posedge clock) begin : sender
      req_type next_item;
      if (reset) begin
         req_valid   <= 1'b0;
         string_hash = HASH_SEED;
         entry_hash  = 64'd0;
         set_hash    = HASH_SEED;
      end else begin
         if (req_valid && !req_stall) begin
            advance_hashes(req_data);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               next_item = pending_items.pop_front();
               req_valid <= 1'b1;
               req_data  <= next_item;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall behavior switches between a few styles, each held for a random stretch.
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_style = stall_style_type'($urandom_range(0, 3));
            stall_left  = $urandom_range(8, 120);
         end else begin
            stall_left--;
         end
         case (stall_style)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
            STALL_TOGGLE: rsp_stall <= ~rsp_stall;
            default:      rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_hashes.size() == 0) begin
            $error("unexpected result: hash_value %h hash_kind %0d",
                   rsp_data.hash_value, rsp_data.hash_kind);
            fail_count++;
         end else begin
            want = expected_hashes.pop_front();
            if (rsp_data.hash_value !== want.hash_value) begin
               $error("hash_value mismatch: expected %h, actual %h",
                      want.hash_value, rsp_data.hash_value);
               fail_count++;
            end
            if (rsp_data.hash_kind !== want.hash_kind) begin
               $error("hash_kind mismatch: expected %0d, actual %0d",
                      want.hash_kind, rsp_data.hash_kind);
               fail_count++;
            end
            checked_count++;
         end
      end
   end

   initial begin : main
      int directed_count;
      int pick;

      // Empty strings, the untouched set, and a suffix closed before any path.
      push_control(MODE_EMIT_STRING);
      push_control(MODE_EMIT_SET);
      push_control(MODE_CLOSE_SFX);
      push_control(MODE_EMIT_SET);
      push_item(MODE_BYTE, 8'h00);
      push_item(MODE_BYTE, 8'hff);
      push_item(MODE_EMIT_STRING, 8'hff);
      push_item(MODE_CLOSE_PATH, 8'h00);
      push_text("MISSING");
      push_item(MODE_CLOSE_SFX, 8'hff);
      // Spare modes must leave every accumulator alone.
      for (int m = int'(MODE_FIRST_SPARE); m <= int'(MODE_LAST_SPARE); m++) begin
         push_item(m[2:0], 8'hff);
      end
      push_control(MODE_EMIT_SET);
      push_item(MODE_BYTE, 8'h41);
      push_control(MODE_CLOSE_PATH);
      push_control(MODE_CLOSE_SFX);
      push_control(MODE_EMIT_SET);
      directed_count = queued_count;

      while (queued_count < directed_count + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            push_snapshot();
         end else if (pick < 82) begin
            push_random_bytes(12);
            push_control(MODE_EMIT_STRING);
         end else if (pick < 92) begin
            // Broken sequence: stray bytes ended by any valid control mode.
            push_random_bytes(6);
            push_control(3'($urandom_range(MODE_CLOSE_PATH, MODE_EMIT_STRING)));
         end else begin
            repeat ($urandom_range(1, 8)) begin
               push_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid) @(posedge clock);
      while (expected_hashes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (expected_hashes.size() != 0) begin
         $error("%0d expected results never arrived", expected_hashes.size());
         fail_count++;
      end
      $display("Sent %0d transactions (%0d snapshot sequences) with random gaps and stalls.",
               accepted_count, snapshot_count);
      $display("Checked %0d emitted hashes, %0d errors.", checked_count, fail_count);
      if (fail_count == 0) begin
         $display("fnv_chained_snapshot_hash regression: pass");
      end else begin
         $display("fnv_chained_snapshot_hash regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #8_000_000;
      $display("Timed out with %0d items pending and %0d results outstanding.",
               pending_items.size(), expected_hashes.size());
      $display("fnv_chained_snapshot_hash regression: fail");
      $finish;
   end

endmodule
